### hw/rtl/eovg_pkg.sv
// ----------------------------------------------------------------------------
// eovg_pkg
// Shared types and constants for the ellipse outline vertex generator:
// vertex kinds, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package eovg_pkg;

  // Default coordinate width.
  localparam int unsigned COORD_BITS_DEF = 12;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_RIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_BOTTOM = 2'd3;

  localparam int unsigned KIND_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_GAP   = 2'd0,
    KIND_ROW   = 2'd1,
    KIND_CLOSE = 2'd2
  } vertex_kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         load_row;
    logic         mul_hh;
    logic         mul_yy;
    logic         mul_ww;
    logic         mul_num;
    logic         div_step;
    logic         sqrt_init;
    logic         sqrt_step;
    logic         load_out;
    vertex_kind_e kind;
    logic         commit_x;
  } eovg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic row_ok;
    logic gap_needed;
    logic final_row;
  } eovg_stat_t;

endpackage

### hw/rtl/eovg_datapath.sv
// ----------------------------------------------------------------------------
// eovg_datapath
// Box registers, multiply steps, serial restoring divider, serial
// square root, stored half width and the output vertex register.
// ----------------------------------------------------------------------------
module eovg_datapath #(
  parameter int unsigned COORD_BITS = eovg_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [eovg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COORD_BITS-1:0]          cfg_data_i,
  input  logic [COORD_BITS-2:0]          row_i,
  input  eovg_pkg::eovg_cmd_t            cmd_i,
  output eovg_pkg::eovg_stat_t           stat_o,
  output logic [COORD_BITS-1:0]          left_x_o,
  output logic [COORD_BITS-1:0]          right_x_o,
  output logic [COORD_BITS-1:0]          lower_y_o,
  output logic [COORD_BITS-1:0]          upper_y_o,
  output logic [eovg_pkg::KIND_W-1:0]    vertex_kind_o,
  output logic                           is_last_o
);
  import eovg_pkg::*;

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned NUM_W = 4 * C;
  localparam int unsigned DEN_W = 2 * C + 2;

  logic [C-1:0] box_left_q, box_top_q, box_right_q, box_bottom_q;
  logic [C-1:0] prev_x_q;
  logic [C-2:0] row_q;

  logic [2*C-1:0]   hh_q, ww_q, diff_q;
  logic [2*C-3:0]   yy_q;
  logic [NUM_W-1:0] acc_q;
  logic [DEN_W-1:0] rem_q;

  logic [2*C-1:0] sq_q;
  logic [C-1:0]   root_q;
  logic [C+1:0]   srem_q;

  logic [C-1:0]   w, h, x, x1, y_ext, ym1;
  logic [C:0]     w_p1, h_p1;
  logic [C-1:0]   half_lo_x, half_hi_x, half_lo_y, half_hi_y;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   rem_sh;
  logic [C+3:0]     srem_sh;
  logic [C+3:0]     trial;

  assign w     = box_right_q - box_left_q;
  assign h     = box_bottom_q - box_top_q;
  assign w_p1  = {1'b0, w} + {{C{1'b0}}, 1'b1};
  assign h_p1  = {1'b0, h} + {{C{1'b0}}, 1'b1};
  assign x     = root_q;
  assign x1    = x + {{(C-1){1'b0}}, 1'b1};
  assign y_ext = {1'b0, row_q};
  assign ym1   = y_ext - {{(C-1){1'b0}}, 1'b1};

  assign half_lo_x = box_left_q + (w >> 1);
  assign half_hi_x = box_left_q + w_p1[C:1];
  assign half_lo_y = box_top_q + (h >> 1);
  assign half_hi_y = box_top_q + h_p1[C:1];

  assign den     = {hh_q, 2'b00};
  assign rem_sh  = {rem_q, acc_q[NUM_W-1]};
  assign srem_sh = {srem_q, sq_q[2*C-1:2*C-2]};
  assign trial   = {2'b00, root_q, 2'b01};

  assign stat_o.row_ok = (box_right_q > box_left_q) && (box_bottom_q > box_top_q) &&
                         (y_ext <= (h >> 1));
  assign stat_o.final_row  = (y_ext == (h >> 1));
  // A gap vertex is needed when the half width fell by two or more.
  assign stat_o.gap_needed = (row_q != '0) && ({1'b0, prev_x_q} > {1'b0, x1});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_left_q   <= '0;
      box_top_q    <= '0;
      box_right_q  <= '0;
      box_bottom_q <= '0;
      prev_x_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BOX_LEFT:   box_left_q   <= cfg_data_i;
          CFG_BOX_TOP:    box_top_q    <= cfg_data_i;
          CFG_BOX_RIGHT:  box_right_q  <= cfg_data_i;
          CFG_BOX_BOTTOM: box_bottom_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.commit_x) begin
        prev_x_q <= x;
      end
    end
  end

  // Arithmetic registers carry no reset; the controller sequences them.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_row) begin
      row_q <= row_i;
    end
    if (cmd_i.mul_hh) begin
      hh_q <= (2*C)'(h) * (2*C)'(h);
    end
    if (cmd_i.mul_yy) begin
      yy_q <= (2*C-2)'(row_q) * (2*C-2)'(row_q);
    end
    if (cmd_i.mul_ww) begin
      ww_q   <= (2*C)'(w) * (2*C)'(w);
      diff_q <= hh_q - {yy_q, 2'b00};
    end
    if (cmd_i.mul_num) begin
      acc_q <= NUM_W'(ww_q) * NUM_W'(diff_q);
      rem_q <= '0;
    end
    // One quotient bit per cycle; the quotient replaces the numerator bits.
    if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, den}) begin
        rem_q <= DEN_W'(rem_sh - {1'b0, den});
        acc_q <= {acc_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DEN_W-1:0];
        acc_q <= {acc_q[NUM_W-2:0], 1'b0};
      end
    end
    if (cmd_i.sqrt_init) begin
      sq_q   <= acc_q[2*C-1:0];
      root_q <= '0;
      srem_q <= '0;
    end
    // One root bit per cycle, two operand bits brought down each time.
    if (cmd_i.sqrt_step) begin
      sq_q <= {sq_q[2*C-3:0], 2'b00};
      if (srem_sh >= trial) begin
        srem_q <= (C+2)'(srem_sh - trial);
        root_q <= {root_q[C-2:0], 1'b1};
      end else begin
        srem_q <= srem_sh[C+1:0];
        root_q <= {root_q[C-2:0], 1'b0};
      end
    end
    if (cmd_i.load_out) begin
      vertex_kind_o <= cmd_i.kind;
      case (cmd_i.kind)
        KIND_GAP: begin
          left_x_o  <= half_lo_x - x1;
          right_x_o <= half_hi_x + x1;
          lower_y_o <= half_hi_y + ym1;
          upper_y_o <= half_lo_y - ym1;
          is_last_o <= 1'b0;
        end
        KIND_CLOSE: begin
          left_x_o  <= half_hi_x;
          right_x_o <= half_hi_x;
          lower_y_o <= box_bottom_q;
          upper_y_o <= box_top_q;
          is_last_o <= 1'b1;
        end
        default: begin
          left_x_o  <= half_lo_x - x;
          right_x_o <= half_hi_x + x;
          lower_y_o <= half_hi_y + y_ext;
          upper_y_o <= half_lo_y - y_ext;
          is_last_o <= 1'b0;
        end
      endcase
    end
  end

endmodule

### hw/rtl/eovg_ctrl.sv
// ----------------------------------------------------------------------------
// eovg_ctrl
// Sequencer: accepts a row and, for a valid one, steps the multiply, divide
// and square-root phases, then hands out up to three vertices through the output register.
// ----------------------------------------------------------------------------
module eovg_ctrl #(
  parameter int unsigned COORD_BITS = eovg_pkg::COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  output logic                  m_valid_o,
  input  logic                  m_ready_i,
  output eovg_pkg::eovg_cmd_t   cmd_o,
  input  eovg_pkg::eovg_stat_t  stat_i
);
  import eovg_pkg::*;

  localparam int unsigned DIV_STEPS = 4 * COORD_BITS;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);

  typedef enum logic [11:0] {
    ST_IDLE       = 12'b000000000001,
    ST_CHECK      = 12'b000000000010,
    ST_MUL_HH     = 12'b000000000100,
    ST_MUL_YY     = 12'b000000001000,
    ST_MUL_WW     = 12'b000000010000,
    ST_MUL_NUM    = 12'b000000100000,
    ST_DIV        = 12'b000001000000,
    ST_SQRT_INIT  = 12'b000010000000,
    ST_SQRT       = 12'b000100000000,
    ST_EMIT_GAP   = 12'b001000000000,
    ST_EMIT_ROW   = 12'b010000000000,
    ST_EMIT_CLOSE = 12'b100000000000
  } state_e;

  state_e     state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic       m_valid_q, m_valid_d;
  logic       slot_free;

  assign slot_free = !m_valid_q || m_ready_i;
  assign m_valid_o = m_valid_q;
  assign s_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    m_valid_d = m_valid_q && !m_ready_i;
    cmd_o     = '0;
    cmd_o.kind = KIND_ROW;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load_row = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = stat_i.row_ok ? ST_MUL_HH : ST_IDLE;
      end
      ST_MUL_HH: begin
        cmd_o.mul_hh = 1'b1;
        state_d = ST_MUL_YY;
      end
      ST_MUL_YY: begin
        cmd_o.mul_yy = 1'b1;
        state_d = ST_MUL_WW;
      end
      ST_MUL_WW: begin
        cmd_o.mul_ww = 1'b1;
        state_d = ST_MUL_NUM;
      end
      ST_MUL_NUM: begin
        cmd_o.mul_num = 1'b1;
        cnt_d = CNT_W'(DIV_STEPS - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_SQRT_INIT;
        end
      end
      ST_SQRT_INIT: begin
        cmd_o.sqrt_init = 1'b1;
        cnt_d = CNT_W'(COORD_BITS - 1);
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_EMIT_GAP;
        end
      end
      ST_EMIT_GAP: begin
        if (!stat_i.gap_needed) begin
          state_d = ST_EMIT_ROW;
        end else if (slot_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.kind     = KIND_GAP;
          m_valid_d      = 1'b1;
          state_d        = ST_EMIT_ROW;
        end
      end
      ST_EMIT_ROW: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.kind     = KIND_ROW;
          cmd_o.commit_x = 1'b1;
          m_valid_d      = 1'b1;
          state_d        = stat_i.final_row ? ST_EMIT_CLOSE : ST_IDLE;
        end
      end
      ST_EMIT_CLOSE: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.kind     = KIND_CLOSE;
          m_valid_d      = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

endmodule

### hw/rtl/ellipse_outline_vertex_generator.sv
// ----------------------------------------------------------------------------
// ellipse_outline_vertex_generator
// Produces the mirrored quarter-outline vertices of an ellipse inscribed in
// the configured box, one input row at a time.
// ----------------------------------------------------------------------------
// A row is checked, then passes the multiply steps, the serial restoring
// divider, which produces one quotient bit per cycle over the
// 4*COORD_BITS-bit numerator, and the square root unit, which produces one
// root bit per cycle, before its first vertex goes out; each further vertex
// waits for the sink to take the one before. A rejected row (empty box or
// row past the end) gives no vertex. One row is in work at a time.
module ellipse_outline_vertex_generator #(
  parameter int unsigned COORD_BITS = eovg_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [eovg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COORD_BITS-1:0]          cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // row_index
  input  logic [((COORD_BITS+6)/8)*8-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // left_x, right_x, lower_y, upper_y
  output logic [((4*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  // vertex_kind
  output logic [eovg_pkg::KIND_W-1:0]    m_axis_tuser,
  output logic                           m_axis_tlast
);
  import eovg_pkg::*;

  localparam int unsigned OUT_W = ((4*COORD_BITS+7)/8)*8;

  eovg_cmd_t  cmd;
  eovg_stat_t stat;
  logic [COORD_BITS-1:0] left_x, right_x, lower_y, upper_y;

  eovg_ctrl #(
    .COORD_BITS(COORD_BITS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd),
    .stat_i    (stat)
  );

  eovg_datapath #(
    .COORD_BITS(COORD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .row_i         (s_axis_tdata[COORD_BITS-2:0]),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .left_x_o      (left_x),
    .right_x_o     (right_x),
    .lower_y_o     (lower_y),
    .upper_y_o     (upper_y),
    .vertex_kind_o (m_axis_tuser),
    .is_last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_W'({upper_y, lower_y, right_x, left_x});

endmodule

### test/eovg_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// eovg_checker
// Watches the configuration port and both stream channels of the ellipse
// outline vertex generator, predicts the vertices of every accepted row and
// compares each vertex transaction with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module eovg_checker #(
  parameter int unsigned COORD_BITS = eovg_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [eovg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [COORD_BITS-1:0]             cfg_data_i,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  // row_index
  input  logic [((COORD_BITS+6)/8)*8-1:0]   s_axis_tdata,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // left_x, right_x, lower_y, upper_y
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  // vertex_kind
  input  logic [eovg_pkg::KIND_W-1:0]       m_axis_tuser,
  input  logic                              m_axis_tlast,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o
);
  import eovg_pkg::*;

  localparam int unsigned CB = COORD_BITS;

  typedef struct packed {
    logic [CB-1:0] left_x;
    logic [CB-1:0] right_x;
    logic [CB-1:0] lower_y;
    logic [CB-1:0] upper_y;
    vertex_kind_e  kind;
    logic          last;
  } vertex_t;

  logic [CB-1:0] box_left, box_top, box_right, box_bottom;
  logic [CB-1:0] prev_half_width;
  vertex_t       vertex_due[$];
  vertex_t       seen, want;
  int unsigned   vertex_no;

  task automatic report(input string msg);
    $display("%0t ns: vertex %0d: %s", $time, vertex_no, msg);
    fail_count_o++;
  endtask

  // Works out the vertices that one row causes and updates the stored width.
  task automatic predict_row(input logic [CB-2:0] row);
    longint unsigned w, h, quot, trial;
    logic [CB-1:0]   x, y, lo_x, hi_x, lo_y, hi_y;
    if (box_right > box_left && box_bottom > box_top) begin
      w = box_right - box_left;
      h = box_bottom - box_top;
      y = {1'b0, row};
      if (y <= h / 2) begin
        quot = (w * w * (h * h - 4 * y * y)) / (4 * h * h);
        // Largest x with x*x <= quot, settled one bit at a time from the top.
        x = '0;
        for (int b = CB - 1; b >= 0; b--) begin
          trial = x | (64'd1 << b);
          if (trial * trial <= quot) x = CB'(trial);
        end
        lo_x = CB'(box_left + w / 2);
        hi_x = CB'(box_left + (w + 1) / 2);
        lo_y = CB'(box_top + h / 2);
        hi_y = CB'(box_top + (h + 1) / 2);
        // A drop of more than one pixel is bridged on the height of the row above.
        if (y != 0 && prev_half_width > x && prev_half_width - x > 1)
          vertex_due.push_back(vertex_t'{lo_x - x - 1'b1, hi_x + x + 1'b1,
                                         hi_y + y - 1'b1, lo_y - y + 1'b1,
                                         KIND_GAP, 1'b0});
        vertex_due.push_back(vertex_t'{lo_x - x, hi_x + x, hi_y + y, lo_y - y,
                                       KIND_ROW, 1'b0});
        if (y == h / 2)
          vertex_due.push_back(vertex_t'{hi_x, hi_x, box_bottom, box_top,
                                         KIND_CLOSE, 1'b1});
        prev_half_width = x;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_left        <= '0;
      box_top         <= '0;
      box_right       <= '0;
      box_bottom      <= '0;
      prev_half_width <= '0;
      vertex_due.delete();
      vertex_no       <= 0;
      fail_count_o    <= 0;
      pending_o       <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen = vertex_t'{m_axis_tdata[CB-1:0], m_axis_tdata[2*CB-1:CB],
                         m_axis_tdata[3*CB-1:2*CB], m_axis_tdata[4*CB-1:3*CB],
                         vertex_kind_e'(m_axis_tuser), m_axis_tlast};
        if (vertex_due.size() == 0) begin
          report("vertex transaction with no vertex expected");
        end else begin
          want = vertex_due.pop_front();
          if (seen.left_x !== want.left_x)
            report($sformatf("left_x %0d, expected %0d", seen.left_x, want.left_x));
          if (seen.right_x !== want.right_x)
            report($sformatf("right_x %0d, expected %0d", seen.right_x, want.right_x));
          if (seen.lower_y !== want.lower_y)
            report($sformatf("lower_y %0d, expected %0d", seen.lower_y, want.lower_y));
          if (seen.upper_y !== want.upper_y)
            report($sformatf("upper_y %0d, expected %0d", seen.upper_y, want.upper_y));
          if (seen.kind !== want.kind)
            report($sformatf("vertex_kind %0d, expected %0d", seen.kind, want.kind));
          if (seen.last !== want.last)
            report($sformatf("is_last %0b, expected %0b", seen.last, want.last));
        end
        vertex_no++;
      end
      if (s_axis_tvalid && s_axis_tready) predict_row(s_axis_tdata[CB-2:0]);
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BOX_LEFT:   box_left   = cfg_data_i;
          CFG_BOX_TOP:    box_top    = cfg_data_i;
          CFG_BOX_RIGHT:  box_right  = cfg_data_i;
          CFG_BOX_BOTTOM: box_bottom = cfg_data_i;
          default: ;
        endcase
      end
      pending_o = vertex_due.size();
    end
  end

endmodule

### test/ellipse_outline_vertex_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ellipse_outline_vertex_generator_tb
// Drives boxes and rows into the ellipse outline vertex generator: a directed
// pass over the corner cases, then random outlines with random idling on both
// streams. A separate checker predicts and compares every vertex.
// ----------------------------------------------------------------------------
module ellipse_outline_vertex_generator_tb;
  import eovg_pkg::*;

  localparam int unsigned CB          = COORD_BITS_DEF;
  localparam int unsigned S_W         = ((CB + 6) / 8) * 8;
  localparam int unsigned M_W         = ((4 * CB + 7) / 8) * 8;
  localparam int unsigned ROW_MAX     = (1 << (CB - 1)) - 1;
  localparam int unsigned COORD_MAX   = (1 << CB) - 1;
  localparam int unsigned SETTLE      = 100;
  localparam int unsigned RANDOM_ROWS = 200;
  localparam int unsigned HOLD_AT     = 150;
  localparam int unsigned HOLD_CYCLES = 400;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CB-1:0]        cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_W-1:0]       s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_W-1:0]       m_axis_tdata;
  logic [KIND_W-1:0]    m_axis_tuser;
  logic                 m_axis_tlast;

  int unsigned fails;
  int unsigned pending;
  int unsigned live_rows;
  int unsigned cur_l, cur_t, cur_r, cur_b;
  logic        tx_calm, rx_calm;

  always #5 clk_i = ~clk_i;

  ellipse_outline_vertex_generator #(.COORD_BITS(CB)) i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  eovg_checker #(.COORD_BITS(CB)) i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .fail_count_o(fails), .pending_o(pending)
  );

  // Stops offering rows, waits for every expected vertex, then lets a row
  // that gives no vertex run out of the block.
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic set_box(input int unsigned l, t, r, b);
    logic [CFG_IDX_W-1:0] idx[4];
    logic [CB-1:0]        val[4];
    idx = '{CFG_BOX_LEFT, CFG_BOX_TOP, CFG_BOX_RIGHT, CFG_BOX_BOTTOM};
    val = '{l, t, r, b};
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    = 1'b1;
      cfg_index_i = idx[i];
      cfg_data_i  = val[i];
      @(negedge clk_i);
    end
    cfg_we_i = 1'b0;
    {cur_l, cur_t, cur_r, cur_b} = {l, t, r, b};
  endtask

  task automatic send_row(input int unsigned row);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = S_W'(row);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    if (cur_r > cur_l && cur_b > cur_t && row <= (cur_b - cur_t) / 2) live_rows++;
  endtask

  // Vertex sink: a random stall before each transaction, and once a long one
  // so that the block backs up into its row input.
  initial begin : sink
    int unsigned stall;
    int unsigned taken;
    m_axis_tready = 1'b0;
    taken = 0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 16);
      if (taken == HOLD_AT) stall = HOLD_CYCLES;
      if (stall != 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      taken++;
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAIL ellipse_outline_vertex_generator");
    $finish;
  end

  initial begin : stimulus
    int unsigned l, t, w, h, n, pick;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_BOX_LEFT;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    tx_calm       = 1'b0;
    rx_calm       = 1'b0;
    live_rows     = 0;
    {cur_l, cur_t, cur_r, cur_b} = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Registers still at reset: the box is empty, so nothing comes out.
    send_row(0);
    send_row(ROW_MAX);
    // Largest box, with the first rows, the flat end and the final row twice.
    set_box(0, 0, COORD_MAX, COORD_MAX);
    send_row(0);
    send_row(1);
    send_row(ROW_MAX - 7);
    send_row(ROW_MAX - 1);
    send_row(ROW_MAX);
    send_row(ROW_MAX);
    send_row(0);
    // Inverted box and a box of zero height.
    set_box(COORD_MAX, COORD_MAX, 0, 0);
    send_row(0);
    set_box(10, 300, 20, 300);
    send_row(0);
    // One pixel box at the far edge: the first row is also the last, the
    // next one lies past the end.
    set_box(COORD_MAX - 1, 0, COORD_MAX, 1);
    send_row(0);
    send_row(1);
    // Wide, low box: the half width falls steeply on the final row.
    set_box(0, 100, 40, 110);
    for (int r = 0; r <= 5; r++) send_row(r);
    send_row(5);

    live_rows = 0;
    while (live_rows < RANDOM_ROWS) begin
      pick    = $urandom_range(0, 9);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if (pick == 0) begin
        // Arbitrary register values, often no valid box, and stray rows.
        set_box($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        repeat ($urandom_range(1, 6)) send_row($urandom_range(0, ROW_MAX));
      end else begin
        w = $urandom_range(1, COORD_MAX);
        h = (pick == 1) ? $urandom_range(61, COORD_MAX) : $urandom_range(1, 60);
        l = $urandom_range(0, COORD_MAX - w);
        t = $urandom_range(0, COORD_MAX - h);
        set_box(l, t, l + w, t + h);
        if (pick == 1) begin
          // Tall box: only the rows next to the end, where the gaps appear.
          n = $urandom_range(0, 12);
          for (int r = h / 2 - n; r <= h / 2; r++) send_row(r);
        end else if (pick == 2) begin
          // Rows repeated or skipped, running up to one row past the end.
          for (int r = 0; r <= h / 2 + 1; r += $urandom_range(0, 2)) send_row(r);
        end else begin
          for (int r = 0; r <= h / 2; r++) send_row(r);
        end
      end
    end

    wait_drained();
    if (fails == 0) begin
      $display("PASS ellipse_outline_vertex_generator");
    end else begin
      $display("FAIL ellipse_outline_vertex_generator");
    end
    $finish;
  end

endmodule
